[rtl/core/fpsr_pkg.sv]
// ----------------------------------------------------------------------------
// fpsr_pkg
// Shared types and constants of the five-point stencil residual block.
// ----------------------------------------------------------------------------
package fpsr_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_GRID_COLS      = 3'd0;
   localparam logic [2:0] REG_GRID_ROWS      = 3'd1;
   localparam logic [2:0] REG_COEF_X         = 3'd2;
   localparam logic [2:0] REG_COEF_Y         = 3'd3;
   localparam logic [2:0] REG_SOURCE_GAIN    = 3'd4;
   localparam logic [2:0] REG_SOURCE_ENABLE  = 3'd5;
   localparam logic [2:0] REG_BOUNDARY_VALUE = 3'd6;

   // Grid limits
   localparam int ROW_LIMIT = 1024;
   localparam int MIN_SIZE  = 3;

   // Fixed-point constants
   localparam logic [63:0] LN2_Q30   = 64'd744261118;
   localparam logic [63:0] ONE_Q30   = 64'd1073741824;
   localparam logic [31:0] TWO_Q30   = 32'h8000_0000;
   localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
   localparam int EXP_TERMS = 24;

   typedef struct packed {
      logic [10:0]        grid_cols;
      logic [10:0]        grid_rows;
      logic [31:0]        coef_x;
      logic [31:0]        coef_y;
      logic signed [31:0] source_gain;
      logic               source_enable;
      logic signed [31:0] boundary_value;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      grid_cols:      11'd5,
      grid_rows:      11'd5,
      coef_x:         32'd65536,
      coef_y:         32'd65536,
      source_gain:    32'sd10240,
      source_enable:  1'b1,
      boundary_value: 32'sd0
   };

   // 2^(k/N) in Q2.30 as a truncated series of exp(t), t = k*ln2/N in Q30
   function automatic logic [31:0] exp_series(input logic [63:0] t);
      logic [63:0] sum;
      logic [63:0] term;
      begin
         sum  = ONE_Q30;
         term = ONE_Q30;
         for (int n = 1; n <= EXP_TERMS; n++) begin
            term = ((term * t) >> 30) / 64'(n);
            sum  = sum + term;
         end
         exp_series = sum[31:0];
      end
   endfunction

endpackage

[rtl/core/fpsr_csr.sv]
// ----------------------------------------------------------------------------
// fpsr_csr
// APB-style configuration registers; always ready, one register per word.
// ----------------------------------------------------------------------------
module fpsr_csr
   import fpsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_xfer;

   assign reg_idx = paddr[4:2];
   assign wr_xfer = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_xfer) begin
         unique case (reg_idx)
            REG_GRID_COLS:      cfg_in.grid_cols      = pwdata[10:0];
            REG_GRID_ROWS:      cfg_in.grid_rows      = pwdata[10:0];
            REG_COEF_X:         cfg_in.coef_x         = pwdata;
            REG_COEF_Y:         cfg_in.coef_y         = pwdata;
            REG_SOURCE_GAIN:    cfg_in.source_gain    = $signed(pwdata);
            REG_SOURCE_ENABLE:  cfg_in.source_enable  = pwdata[0];
            REG_BOUNDARY_VALUE: cfg_in.boundary_value = $signed(pwdata);
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_GRID_COLS:      prdata = {21'd0, cfg_ff.grid_cols};
         REG_GRID_ROWS:      prdata = {21'd0, cfg_ff.grid_rows};
         REG_COEF_X:         prdata = cfg_ff.coef_x;
         REG_COEF_Y:         prdata = cfg_ff.coef_y;
         REG_SOURCE_GAIN:    prdata = cfg_ff.source_gain;
         REG_SOURCE_ENABLE:  prdata = {31'd0, cfg_ff.source_enable};
         REG_BOUNDARY_VALUE: prdata = cfg_ff.boundary_value;
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/fpsr_line_buf.sv]
// ----------------------------------------------------------------------------
// fpsr_line_buf
// Two row buffers (row above, center row); one write and one registered
// read per buffer each cycle.
// ----------------------------------------------------------------------------
module fpsr_line_buf
   import fpsr_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
)
(
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_above_data,
   input  logic [31:0]   wr_center_data,
   input  logic [AW-1:0] rd_above_addr,
   input  logic [AW-1:0] rd_center_addr,
   output logic [31:0]   rd_above_data,
   output logic [31:0]   rd_center_data
);

   logic [31:0] above_mem [DEPTH];
   logic [31:0] center_mem [DEPTH];

   // row above
   always_ff @(posedge clock) begin
      if (wr_en) begin
         above_mem[wr_addr] <= wr_above_data;
      end
      rd_above_data <= above_mem[rd_above_addr];
   end

   // center row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         center_mem[wr_addr] <= wr_center_data;
      end
      rd_center_data <= center_mem[rd_center_addr];
   end

endmodule

[rtl/core/fpsr_exp_table.sv]
// ----------------------------------------------------------------------------
// fpsr_exp_table
// Constant table of 2^(k/N) in Q2.30 with the neighbor entry for
// interpolation; the entry past the end is exactly 2.0.
// ----------------------------------------------------------------------------
module fpsr_exp_table
   import fpsr_pkg::*;
#(
   parameter int ENTRIES = 256,
   parameter int IW      = 8
)
(
   input  logic [IW-1:0] idx,
   output logic [31:0]   lo,
   output logic [31:0]   hi
);

   logic [31:0] tab [ENTRIES];
   logic [IW:0] idx_next;

   // table contents fixed at elaboration
   for (genvar k = 0; k < ENTRIES; k++) begin : g_tab
      localparam logic [63:0] T = (64'(k) * LN2_Q30) / ENTRIES;
      assign tab[k] = exp_series(T);
   end

   assign idx_next = {1'b0, idx} + (IW+1)'(1);
   assign lo = tab[idx];
   assign hi = (idx_next < (IW+1)'(ENTRIES)) ? tab[idx_next[IW-1:0]] : TWO_Q30;

endmodule

[rtl/core/five_point_stencil_residual.sv]
// ----------------------------------------------------------------------------
// five_point_stencil_residual
// Streams a raster-order grid and returns the five-point Laplacian residual
// with an optional exponential source; border points give boundary_value.
// ----------------------------------------------------------------------------
// One sample is handled at a time. The point one row up is emitted when the
// sample below it arrives, and samples of the last row also emit their own
// border point. On the first row, which emits nothing, an item passes accept
// and two line buffer reads. Border points add a result load; interior
// points add the shared coefficient multiplier (four partial products)
// before the result load, and with the source term also the serial exp steps
// (log2 scale, table index, interpolation, shift, gain product). A second
// result load follows on the last row. A finished result sits in an output
// register, so a stalled consumer holds back only the next result load. Line
// buffers are not cleared after reset; no clearing pass is run.
// ----------------------------------------------------------------------------
module five_point_stencil_residual
   import fpsr_pkg::*;
#(
   parameter int MAX_COLS          = 1024,
   parameter int EXP_TABLE_ENTRIES = 256
)
(
   input  logic                  clock,
   input  logic                  reset,
   // sample channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_sample,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_residual,
   output logic [9:0]            rsp_row_index,
   output logic [9:0]            rsp_col_index,
   output logic                  rsp_last_point,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW  = $clog2(MAX_COLS);
   localparam int CW0 = $clog2(MAX_COLS + 1);
   localparam int CW  = (CW0 > 11) ? CW0 : 11;
   localparam int IW  = $clog2(EXP_TABLE_ENTRIES);
   localparam int FW  = 16 + IW;

   typedef enum logic [3:0] {
      S_IDLE, S_RD2, S_NBR, S_XH, S_XL, S_YH, S_YL,
      S_LOG, S_TAB, S_INT, S_EXP, S_SRC, S_OUT1, S_OUT2
   } state_type;

   cfg_type cfg;

   // control registers
   state_type          state_ff, state_in;
   logic [CW-1:0]      col_cnt_ff, col_cnt_in;
   logic [9:0]         row_cnt_ff, row_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // item and datapath registers
   logic [CW-1:0]      c_ff, c_in;
   logic [9:0]         r_ff, r_in;
   logic signed [31:0] sample_ff, sample_in;
   logic               first_ff, first_in;
   logic               interior_ff, interior_in;
   logic               second_ff, second_in;
   logic               last_ff, last_in;
   logic signed [31:0] u_ff, u_in;
   logic signed [31:0] un_ff, un_in;
   logic signed [34:0] dx_ff, dx_in;
   logic signed [34:0] dy_ff, dy_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [33:0] y_ff, y_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [15:0]        w_ff, w_in;
   logic [31:0]        m_ff, m_in;
   logic [31:0]        exp_ff, exp_in;
   logic signed [31:0] rsp_residual_ff, rsp_residual_in;
   logic [9:0]         rsp_row_ff, rsp_row_in;
   logic [9:0]         rsp_col_ff, rsp_col_in;
   logic               rsp_last_ff, rsp_last_in;

   // sizes and position of the incoming sample
   logic [CW-1:0]      gc, cols;
   logic [10:0]        rows;
   logic               col_wrap;
   logic [CW-1:0]      c_cur;
   logic [10:0]        r_inc;
   logic [9:0]         r_cur;
   logic [CW-1:0]      c_plus, c_minus;

   // line buffer port
   logic               wr_en;
   logic [AW-1:0]      rd_above_addr, rd_center_addr;
   logic [31:0]        rd_above_data, rd_center_data;

   // arithmetic
   logic signed [34:0] u35;
   logic signed [34:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [51:0] mul_p;
   logic signed [63:0] log_p;
   logic [FW-1:0]      fn;
   logic [31:0]        tab_lo, tab_hi;
   logic [32:0]        diff;
   logic [48:0]        int_p;
   logic signed [17:0] pow2;
   logic [4:0]         shamt;
   logic signed [64:0] src_p;
   logic signed [31:0] acc_sat;
   logic               slot_free;

   fpsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fpsr_line_buf #(
      .DEPTH (MAX_COLS),
      .AW    (AW)
   ) u_line_buf (
      .clock          (clock),
      .wr_en          (wr_en),
      .wr_addr        (c_ff[AW-1:0]),
      .wr_above_data  (rd_center_data),
      .wr_center_data (sample_ff),
      .rd_above_addr  (rd_above_addr),
      .rd_center_addr (rd_center_addr),
      .rd_above_data  (rd_above_data),
      .rd_center_data (rd_center_data)
   );

   fpsr_exp_table #(
      .ENTRIES (EXP_TABLE_ENTRIES),
      .IW      (IW)
   ) u_exp_table (
      .idx (idx_ff),
      .lo  (tab_lo),
      .hi  (tab_hi)
   );

   // clamp grid size
   assign gc   = CW'(cfg.grid_cols);
   assign cols = (gc < CW'(MIN_SIZE)) ? CW'(MIN_SIZE) :
                 ((gc > CW'(MAX_COLS)) ? CW'(MAX_COLS) : gc);
   assign rows = (cfg.grid_rows < 11'(MIN_SIZE)) ? 11'(MIN_SIZE) :
                 ((cfg.grid_rows > 11'(ROW_LIMIT)) ? 11'(ROW_LIMIT) : cfg.grid_rows);

   // counter wrap before the sample is used
   assign col_wrap = (col_cnt_ff >= cols);
   assign c_cur    = col_wrap ? '0 : col_cnt_ff;
   assign r_inc    = {1'b0, row_cnt_ff} + (col_wrap ? 11'd1 : 11'd0);
   assign r_cur    = (r_inc >= rows) ? 10'd0 : r_inc[9:0];

   // neighbor reads: own column at accept, then east (center) and west (above)
   assign c_plus         = c_ff + CW'(1);
   assign c_minus        = c_ff - CW'(1);
   assign rd_center_addr = (state_ff == S_IDLE) ? c_cur[AW-1:0] : c_plus[AW-1:0];
   assign rd_above_addr  = (state_ff == S_IDLE) ? c_cur[AW-1:0] : c_minus[AW-1:0];
   assign wr_en          = (state_ff == S_RD2);

   // shared coefficient multiplier
   assign mul_a = ((state_ff == S_XH) || (state_ff == S_XL)) ? dx_ff : dy_ff;
   always_comb begin
      case (state_ff)
         S_XH:    mul_b = $signed({1'b0, cfg.coef_x[31:16]});
         S_XL:    mul_b = $signed({1'b0, cfg.coef_x[15:0]});
         S_YH:    mul_b = $signed({1'b0, cfg.coef_y[31:16]});
         default: mul_b = $signed({1'b0, cfg.coef_y[15:0]});
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // exp steps
   assign u35   = 35'(u_ff);
   assign log_p = u_ff * LOG2E_Q30;
   assign fn    = FW'(y_ff[15:0]) * FW'(EXP_TABLE_ENTRIES);
   assign diff  = {1'b0, tab_hi} - {1'b0, tab_lo};
   assign int_p = diff * {33'd0, w_ff};
   assign pow2  = y_ff[33:16];
   assign shamt = 5'(18'sd14 - pow2);
   assign src_p = cfg.source_gain * $signed({1'b0, exp_ff});

   // saturate to signed 32 bits
   always_comb begin
      if (acc_ff > 64'sd2147483647) begin
         acc_sat = 32'sh7FFF_FFFF;
      end else if (acc_ff < -64'sd2147483648) begin
         acc_sat = 32'sh8000_0000;
      end else begin
         acc_sat = acc_ff[31:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      col_cnt_in      = col_cnt_ff;
      row_cnt_in      = row_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      c_in            = c_ff;
      r_in            = r_ff;
      sample_in       = sample_ff;
      first_in        = first_ff;
      interior_in     = interior_ff;
      second_in       = second_ff;
      last_in         = last_ff;
      u_in            = u_ff;
      un_in           = un_ff;
      dx_in           = dx_ff;
      dy_in           = dy_ff;
      acc_in          = acc_ff;
      y_in            = y_ff;
      idx_in          = idx_ff;
      w_in            = w_ff;
      m_in            = m_ff;
      exp_in          = exp_ff;
      rsp_residual_in = rsp_residual_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               col_cnt_in  = c_cur + CW'(1);
               row_cnt_in  = r_cur;
               c_in        = c_cur;
               r_in        = r_cur;
               sample_in   = req_sample;
               first_in    = (r_cur != 10'd0);
               interior_in = (r_cur >= 10'd2) && (c_cur != '0) && (c_cur < cols - CW'(1));
               second_in   = ({1'b0, r_cur} == rows - 11'd1);
               last_in     = (c_cur == cols - CW'(1));
               state_in    = S_RD2;
            end
         end
         S_RD2: begin
            // own column arrives; shift the column down the buffers
            u_in     = $signed(rd_center_data);
            un_in    = $signed(rd_above_data);
            state_in = S_NBR;
         end
         S_NBR: begin
            dx_in  = (u35 <<< 1) - 35'($signed(rd_above_data))
                     - 35'($signed(rd_center_data));
            dy_in  = (u35 <<< 1) - 35'(un_ff) - 35'(sample_ff);
            acc_in = 64'(cfg.boundary_value);
            if (interior_ff) begin
               state_in = S_XH;
            end else if (first_ff) begin
               state_in = S_OUT1;
            end else if (second_ff) begin
               state_in = S_OUT2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_XH: begin
            acc_in   = 64'(mul_p);
            state_in = S_XL;
         end
         S_XL: begin
            acc_in   = acc_ff + 64'(mul_p >>> 16);
            state_in = S_YH;
         end
         S_YH: begin
            acc_in   = acc_ff + 64'(mul_p);
            state_in = S_YL;
         end
         S_YL: begin
            acc_in   = acc_ff + 64'(mul_p >>> 16);
            state_in = cfg.source_enable ? S_LOG : S_OUT1;
         end
         S_LOG: begin
            y_in     = log_p[63:30];
            state_in = S_TAB;
         end
         S_TAB: begin
            idx_in   = fn[FW-1:16];
            w_in     = fn[15:0];
            state_in = S_INT;
         end
         S_INT: begin
            m_in     = tab_lo + int_p[47:16];
            state_in = S_EXP;
         end
         S_EXP: begin
            if (pow2 >= 18'sd15) begin
               exp_in = 32'h7FFF_FFFF;
            end else if (pow2 <= -18'sd17) begin
               exp_in = 32'd0;
            end else begin
               exp_in = m_ff >> shamt;
            end
            state_in = S_SRC;
         end
         S_SRC: begin
            acc_in   = acc_ff - 64'(src_p >>> 16);
            state_in = S_OUT1;
         end
         S_OUT1: begin
            // point one row up
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_residual_in = acc_sat;
               rsp_row_in      = r_ff - 10'd1;
               rsp_col_in      = c_ff[9:0];
               rsp_last_in     = 1'b0;
               state_in        = second_ff ? S_OUT2 : S_IDLE;
            end
         end
         S_OUT2: begin
            // own border point on the last row
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_residual_in = cfg.boundary_value;
               rsp_row_in      = r_ff;
               rsp_col_in      = c_ff[9:0];
               rsp_last_in     = last_ff;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff            <= c_in;
      r_ff            <= r_in;
      sample_ff       <= sample_in;
      first_ff        <= first_in;
      interior_ff     <= interior_in;
      second_ff       <= second_in;
      last_ff         <= last_in;
      u_ff            <= u_in;
      un_ff           <= un_in;
      dx_ff           <= dx_in;
      dy_ff           <= dy_in;
      acc_ff          <= acc_in;
      y_ff            <= y_in;
      idx_ff          <= idx_in;
      w_ff            <= w_in;
      m_ff            <= m_in;
      exp_ff          <= exp_in;
      rsp_residual_ff <= rsp_residual_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_residual   = rsp_residual_ff;
   assign rsp_row_index  = rsp_row_ff;
   assign rsp_col_index  = rsp_col_ff;
   assign rsp_last_point = rsp_last_ff;

endmodule
